>>> hdl/mdq_pkg.sv
// Package for the masked interrupt dispatch queue: codes, widths and the
// command record that travels from the front end to the dispatch engine.
// No dependencies.
package mdq_pkg;

	// Field widths fixed by the item format
	localparam int LINE_W    = 5;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int DRAIN_W   = 5;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// Default sizes and the per-drain limit
	localparam int DEF_NUM_LINES   = 32;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS     = 16;

	// Request operations
	localparam logic [OP_W-1:0] OP_FIRE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAIN = 2'd1;
	localparam logic [OP_W-1:0] OP_STATS = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_MASK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFERRED      = 2'd2;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DISPATCHED = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_DROPPED    = 3'd2,
		ST_MASKED     = 3'd3,
		ST_DRAINED    = 3'd4,
		ST_EMPTY      = 3'd5,
		ST_STATS      = 3'd6
	} status_t;

	// Request class decided by the front end
	typedef enum logic [1:0] {
		K_FIRE   = 2'd0,
		K_MASKED = 2'd1,
		K_DRAIN  = 2'd2,
		K_STATS  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [LINE_W-1:0] line;
		logic              in_range;
		logic              deferred;
	} cmd_t;

endpackage

>>> hdl/mdq_ifs.sv
// Channel interfaces of the interrupt dispatch queue: request, result and
// configuration write. Depends on mdq_pkg.
interface mdq_req_if;
	import mdq_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [LINE_W-1:0] irq_line;
	modport source (output valid, operation, irq_line, input ready);
	modport sink   (input valid, operation, irq_line, output ready);
endinterface

interface mdq_rsp_if;
	import mdq_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LINE_W-1:0]   line_out;
	logic [DRAIN_W-1:0]  drained_count;
	logic                last_result;
	logic [CNT_W-1:0]    fire_count_out;
	logic [CNT_W-1:0]    queued_total_out;
	logic [CNT_W-1:0]    dropped_total_out;
	modport source (output valid, status, line_out, drained_count, last_result,
		fire_count_out, queued_total_out, dropped_total_out, input ready);
	modport sink   (input valid, status, line_out, drained_count, last_result,
		fire_count_out, queued_total_out, dropped_total_out, output ready);
endinterface

interface mdq_cfg_if;
	import mdq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/masked_interrupt_dispatch_queue.sv
// Masked interrupt dispatch queue: top level joining front end, command queue
// and dispatch engine. Depends on mdq_pkg, mdq_ifs, mdq_front, mdq_cmd_queue, mdq_back.
//
// Usage:
//   irq_req carries requests (operation, irq_line): fire, drain or statistics read.
//   irq_rsp carries results; a drain yields one result per popped line, the
//   final one flagged by last_result. Unknown operations give no result.
//   cfg writes global_enable (0), line_enable_mask (1) and deferred_mode (2);
//   write it only while no request is in flight.
// Timing:
//   A fire or statistics read passes the command queue, the job registers and
//   the result register; the engine takes a new request only once it is back in
//   idle, as the registered read of the fire counter memory comes ahead of the update cycle.
//   A drain gives one result per popped line (ring read, then counter read),
//   up to sixteen per request.
//   The front end keeps transferring requests into a two-entry command queue
//   while the engine works; the engine can take up its next job while the previous
//   result waits, but gives no new result until that one is taken.
// Reset: counters, totals and the ring are cleared at once; the block is ready
//   in the first cycle after reset. When the receiver stalls, the result
//   holds, the engine stops, and requests back up into the command queue.
module masked_interrupt_dispatch_queue #(
	parameter int NUM_LINES   = mdq_pkg::DEF_NUM_LINES,
	parameter int QUEUE_DEPTH = mdq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mdq_req_if.sink   irq_req,
	mdq_rsp_if.source irq_rsp,
	mdq_cfg_if.sink   cfg
);
	import mdq_pkg::*;

	logic front_valid;
	cmd_t front_cmd;
	logic front_ready;
	logic back_valid;
	cmd_t back_cmd;
	logic back_ready;

	mdq_front #(
		.NUM_LINES (NUM_LINES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.irq_req   (irq_req),
		.cfg       (cfg),
		.cmd_valid (front_valid),
		.cmd       (front_cmd),
		.cmd_ready (front_ready)
	);

	mdq_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_cmd   (front_cmd),
		.push_ready (front_ready),
		.pop_valid  (back_valid),
		.pop_cmd    (back_cmd),
		.pop_ready  (back_ready)
	);

	mdq_back #(
		.NUM_LINES   (NUM_LINES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd       (back_cmd),
		.cmd_ready (back_ready),
		.irq_rsp   (irq_rsp)
	);

endmodule

>>> hdl/mdq_front.sv
// Front end: configuration registers, request intake and classification.
// Depends on mdq_pkg and mdq_ifs.
module mdq_front #(
	parameter int NUM_LINES = mdq_pkg::DEF_NUM_LINES
) (
	input  logic          clk,
	input  logic          arst_n,
	mdq_req_if.sink       irq_req,
	mdq_cfg_if.sink       cfg,
	output logic          cmd_valid,
	output mdq_pkg::cmd_t cmd,
	input  logic          cmd_ready
);
	import mdq_pkg::*;

	logic              global_en_q;
	logic [CNT_W-1:0]  line_mask_q;
	logic              deferred_q;
	logic              in_range;
	logic              line_open;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_en_q <= 1'b1;
			line_mask_q <= '1;
			deferred_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_GLOBAL_ENABLE: global_en_q <= cfg.data[0];
				CFG_LINE_MASK:     line_mask_q <= cfg.data;
				CFG_DEFERRED:      deferred_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Classify the request; unknown operations are dropped here
	assign in_range  = 32'(irq_req.irq_line) < 32'(NUM_LINES);
	assign line_open = in_range && global_en_q && line_mask_q[irq_req.irq_line];
	assign irq_req.ready = cmd_ready;

	always_comb begin
		cmd.line     = irq_req.irq_line;
		cmd.in_range = in_range;
		cmd.deferred = deferred_q;
		cmd.kind     = K_STATS;
		cmd_valid    = 1'b0;
		case (irq_req.operation)
			OP_FIRE: begin
				cmd.kind  = line_open ? K_FIRE : K_MASKED;
				cmd_valid = irq_req.valid;
			end
			OP_DRAIN: begin
				cmd.kind  = K_DRAIN;
				cmd_valid = irq_req.valid;
			end
			OP_STATS: begin
				cmd.kind  = K_STATS;
				cmd_valid = irq_req.valid;
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/mdq_cmd_queue.sv
// Two-entry command queue between the front end and the dispatch engine.
// Depends on mdq_pkg.
module mdq_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  mdq_pkg::cmd_t push_cmd,
	output logic          push_ready,
	output logic          pop_valid,
	output mdq_pkg::cmd_t pop_cmd,
	input  logic          pop_ready
);
	import mdq_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = count_q != 2'(DEPTH);
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Hold entries; no reset on the payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hdl/mdq_back.sv
// Dispatch engine: fire counters, pending line ring, totals and result register.
// Depends on mdq_pkg and mdq_ifs.
module mdq_back #(
	parameter int NUM_LINES   = mdq_pkg::DEF_NUM_LINES,
	parameter int QUEUE_DEPTH = mdq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mdq_pkg::cmd_t cmd,
	output logic          cmd_ready,
	mdq_rsp_if.source     irq_rsp
);
	import mdq_pkg::*;

	localparam int LINE_AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int QAW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_EXEC
	} state_t;

	state_t              state_q;
	cmd_kind_t           job_kind_q;
	logic [LINE_W-1:0]   job_line_q;
	logic                job_in_range_q;
	logic                job_def_q;
	logic                job_empty_q;
	logic [DRAIN_W-1:0]  n_q;
	logic                last_q;

	logic [CNT_W-1:0]    cnt_mem [NUM_LINES];
	logic [NUM_LINES-1:0] cnt_vld_q;
	logic [CNT_W-1:0]    rdata_q;
	logic                rvld_q;
	logic [LINE_W-1:0]   pend_mem [QUEUE_DEPTH];
	logic [LINE_W-1:0]   pend_rd_q;

	logic [QAW-1:0]      head_q;
	logic [QAW-1:0]      tail_q;
	logic [FILL_W-1:0]   fill_q;
	logic [CNT_W-1:0]    queued_q;
	logic [CNT_W-1:0]    dropped_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [LINE_W-1:0]   out_line_q;
	logic [DRAIN_W-1:0]  out_drained_q;
	logic                out_last_q;
	logic [CNT_W-1:0]    out_fc_q;
	logic [CNT_W-1:0]    out_queued_q;
	logic [CNT_W-1:0]    out_dropped_q;

	logic [LINE_W-1:0]   rd_line;
	logic [LINE_AW+LINE_W-1:0] rd_wide;
	logic [LINE_AW-1:0]  rd_addr;
	logic [LINE_AW+LINE_W-1:0] job_wide;
	logic [LINE_AW-1:0]  job_addr;
	logic [CNT_W-1:0]    count_rd;
	logic [CNT_W-1:0]    count_inc;
	logic                fill_full;
	logic                emit;
	logic                cnt_wr;
	logic                do_push;
	logic                do_cnt_wr;
	status_t             res_status;
	logic [LINE_W-1:0]   res_line;
	logic [DRAIN_W-1:0]  res_drained;
	logic                res_last;
	logic [CNT_W-1:0]    res_fc;
	logic [CNT_W-1:0]    queued_nxt;
	logic [CNT_W-1:0]    dropped_nxt;
	logic                drain_more;

	// Select the counter read address for the cycle ahead
	always_comb begin
		case (state_q)
			S_IDLE:  rd_line = cmd.line;
			S_POP:   rd_line = pend_rd_q;
			default: rd_line = job_line_q;
		endcase
	end

	assign rd_wide  = {{LINE_AW{1'b0}}, rd_line};
	assign rd_addr  = rd_wide[LINE_AW-1:0];
	assign job_wide = {{LINE_AW{1'b0}}, job_line_q};
	assign job_addr = job_wide[LINE_AW-1:0];

	// Counter memory: one write, one registered read
	always_ff @(posedge clk) begin
		rdata_q <= cnt_mem[rd_addr];
		rvld_q  <= cnt_vld_q[rd_addr];
		if (cnt_wr) begin
			cnt_mem[job_addr] <= count_inc;
		end
	end

	// Pending line ring: write at tail, registered read at head
	always_ff @(posedge clk) begin
		pend_rd_q <= pend_mem[head_q];
		if (do_push && emit) begin
			pend_mem[tail_q] <= job_line_q;
		end
	end

	assign count_rd   = (job_in_range_q && rvld_q) ? rdata_q : '0;
	assign count_inc  = count_rd + CNT_W'(1);
	assign fill_full  = fill_q == FILL_W'(QUEUE_DEPTH);
	assign emit       = (state_q == S_EXEC) && (!out_valid_q || irq_rsp.ready);
	assign cnt_wr     = emit && do_cnt_wr;
	assign cmd_ready  = state_q == S_IDLE;
	assign drain_more = (job_kind_q == K_DRAIN) && !job_empty_q && !last_q;

	// Build the result of the current job
	always_comb begin
		res_status  = ST_STATS;
		res_line    = job_line_q;
		res_drained = '0;
		res_last    = 1'b1;
		res_fc      = count_rd;
		queued_nxt  = queued_q;
		dropped_nxt = dropped_q;
		do_push     = 1'b0;
		do_cnt_wr   = 1'b0;
		case (job_kind_q)
			K_FIRE: begin
				do_cnt_wr = 1'b1;
				res_fc    = count_inc;
				if (!job_def_q) begin
					res_status = ST_DISPATCHED;
				end else if (fill_full) begin
					res_status  = ST_DROPPED;
					dropped_nxt = dropped_q + CNT_W'(1);
				end else begin
					res_status = ST_QUEUED;
					do_push    = 1'b1;
					queued_nxt = queued_q + CNT_W'(1);
				end
			end
			K_MASKED: begin
				res_status = ST_MASKED;
			end
			K_DRAIN: begin
				if (job_empty_q) begin
					res_status = ST_EMPTY;
					res_line   = '0;
					res_fc     = '0;
				end else begin
					res_status  = ST_DRAINED;
					res_drained = n_q;
					res_last    = last_q;
				end
			end
			K_STATS: begin
				res_status = ST_STATS;
			end
			default: ;
		endcase
	end

	// Sequencer, ring pointers, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			job_kind_q     <= K_STATS;
			job_line_q     <= '0;
			job_in_range_q <= 1'b0;
			job_def_q      <= 1'b0;
			job_empty_q    <= 1'b0;
			n_q            <= '0;
			last_q         <= 1'b0;
			cnt_vld_q      <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			fill_q         <= '0;
			queued_q       <= '0;
			dropped_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (!emit && irq_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						job_kind_q     <= cmd.kind;
						job_line_q     <= cmd.line;
						job_in_range_q <= cmd.in_range;
						job_def_q      <= cmd.deferred;
						job_empty_q    <= fill_q == '0;
						n_q            <= '0;
						state_q <= (cmd.kind == K_DRAIN && fill_q != '0) ? S_POP : S_EXEC;
					end
				end
				S_POP: begin
					job_line_q     <= pend_rd_q;
					job_in_range_q <= 1'b1;
					head_q  <= (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
					fill_q  <= fill_q - FILL_W'(1);
					n_q     <= n_q + DRAIN_W'(1);
					last_q  <= (fill_q == FILL_W'(1)) ||
						(n_q + DRAIN_W'(1) == DRAIN_W'(MAX_RESULTS));
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						queued_q    <= queued_nxt;
						dropped_q   <= dropped_nxt;
						if (cnt_wr) begin
							cnt_vld_q[job_addr] <= 1'b1;
						end
						if (do_push) begin
							tail_q <= (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QAW'(1);
							fill_q <= fill_q + FILL_W'(1);
						end
						state_q <= drain_more ? S_POP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload; no reset needed
	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q  <= res_status;
			out_line_q    <= res_line;
			out_drained_q <= res_drained;
			out_last_q    <= res_last;
			out_fc_q      <= res_fc;
			out_queued_q  <= queued_nxt;
			out_dropped_q <= dropped_nxt;
		end
	end

	assign irq_rsp.valid             = out_valid_q;
	assign irq_rsp.status            = out_status_q;
	assign irq_rsp.line_out          = out_line_q;
	assign irq_rsp.drained_count     = out_drained_q;
	assign irq_rsp.last_result       = out_last_q;
	assign irq_rsp.fire_count_out    = out_fc_q;
	assign irq_rsp.queued_total_out  = out_queued_q;
	assign irq_rsp.dropped_total_out = out_dropped_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("pending ring fill beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (fill_q != '0))
		else $error("pop from an empty pending ring");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_last) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after the final result");

	a_queued_count: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_status == ST_QUEUED) |=>
		(queued_q == $past(queued_q) + CNT_W'(1)) && (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("queued fire not counted");
`endif

endmodule

>>> dv/tb.sv
// Testbench for the masked interrupt dispatch queue: directed and random requests,
// configuration writes between phases and a stalling result receiver, all checked
// against an in-bench model. Depends on mdq_pkg, the mdq channel interfaces and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mdq_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		status_t            status;
		logic [LINE_W-1:0]  line;
		logic [DRAIN_W-1:0] drained;
		logic               last;
		logic [CNT_W-1:0]   fires;
		logic [CNT_W-1:0]   queued;
		logic [CNT_W-1:0]   dropped;
	} irq_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mdq_req_if irq_req();
	mdq_rsp_if irq_rsp();
	mdq_cfg_if cfg_bus();

	masked_interrupt_dispatch_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.irq_req(irq_req),
		.irq_rsp(irq_rsp),
		.cfg    (cfg_bus)
	);

	// Model state: configuration, pending ring, counters and totals
	logic              glb_en;
	logic [CNT_W-1:0]  line_mask;
	logic              defer_mode;
	logic [LINE_W-1:0] ring [DEF_QUEUE_DEPTH];
	int                ring_head;
	int                ring_tail;
	int                ring_fill;
	logic [CNT_W-1:0]  fire_cnt [DEF_NUM_LINES];
	logic [CNT_W-1:0]  queued_tot;
	logic [CNT_W-1:0]  dropped_tot;

	irq_result_t irq_results_q[$];
	irq_result_t seen;
	irq_result_t want;
	int          fail_count = 0;
	logic        no_gaps = 1'b0;
	int          rsp_hold = 0;
	logic        hold_active = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Idle lengths: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Lines biased towards both ends of the range
	function automatic logic [LINE_W-1:0] pick_line();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return LINE_W'($urandom);
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int drain_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < drain_pct)
			return OP_DRAIN;
		if (r < drain_pct + 20)
			return OP_STATS;
		if (r < drain_pct + 24)
			return OP_UNUSED;
		return OP_FIRE;
	endfunction

	function automatic string fmt_result(irq_result_t r);
		return $sformatf("status=%0d line=%0d drained=%0d last=%0b fires=%0d queued=%0d dropped=%0d",
			r.status, r.line, r.drained, r.last, r.fires, r.queued, r.dropped);
	endfunction

	// Queue one expected result, stamped with the current totals
	function automatic void expect_result(status_t st, logic [LINE_W-1:0] line, int drained,
		logic last, logic [CNT_W-1:0] fires);
		irq_result_t r;
		r.status  = st;
		r.line    = line;
		r.drained = DRAIN_W'(drained);
		r.last    = last;
		r.fires   = fires;
		r.queued  = queued_tot;
		r.dropped = dropped_tot;
		irq_results_q.push_back(r);
	endfunction

	// Advance the model by one accepted request and queue what it yields
	function automatic void compute_irq_results(logic [OP_W-1:0] op, logic [LINE_W-1:0] line);
		logic [LINE_W-1:0] popped;
		int n;
		case (op)
			OP_FIRE: begin
				if (!glb_en || !line_mask[line]) begin
					expect_result(ST_MASKED, line, 0, 1'b1, fire_cnt[line]);
				end else begin
					fire_cnt[line] = fire_cnt[line] + 1'b1;
					if (!defer_mode) begin
						expect_result(ST_DISPATCHED, line, 0, 1'b1, fire_cnt[line]);
					end else if (ring_fill >= DEF_QUEUE_DEPTH) begin
						dropped_tot = dropped_tot + 1'b1;
						expect_result(ST_DROPPED, line, 0, 1'b1, fire_cnt[line]);
					end else begin
						ring[ring_tail] = line;
						ring_tail = (ring_tail + 1) % DEF_QUEUE_DEPTH;
						ring_fill++;
						queued_tot = queued_tot + 1'b1;
						expect_result(ST_QUEUED, line, 0, 1'b1, fire_cnt[line]);
					end
				end
			end
			OP_DRAIN: begin
				if (ring_fill == 0) begin
					expect_result(ST_EMPTY, '0, 0, 1'b1, '0);
				end else begin
					n = 0;
					while (ring_fill > 0 && n < MAX_RESULTS) begin
						popped = ring[ring_head];
						ring_head = (ring_head + 1) % DEF_QUEUE_DEPTH;
						ring_fill--;
						n++;
						expect_result(ST_DRAINED, popped, n,
							(ring_fill == 0 || n == MAX_RESULTS), fire_cnt[popped]);
					end
				end
			end
			OP_STATS: begin
				expect_result(ST_STATS, line, 0, 1'b1, fire_cnt[line]);
			end
			default: begin
			end
		endcase
	endfunction

	// Offer one request after a random gap and hold it until the transfer
	task automatic send_request(logic [OP_W-1:0] op, logic [LINE_W-1:0] line);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			irq_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		irq_req.valid     <= 1'b1;
		irq_req.operation <= op;
		irq_req.irq_line  <= line;
		do @(posedge clk); while (!irq_req.ready);
		compute_irq_results(op, line);
	endtask

	// Drop the request, wait for every result, then let the block go quiet
	task automatic settle_block();
		irq_req.valid <= 1'b0;
		while (irq_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CFG_GLOBAL_ENABLE: glb_en = val[0];
			CFG_LINE_MASK:     line_mask = val;
			CFG_DEFERRED:      defer_mode = val[0];
			default: begin
			end
		endcase
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result receiver: random stalls, free-running stretches, long hold on request
	initial begin
		int on_len;
		int off_len;
		irq_rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold > 0) begin
				off_len = rsp_hold;
				rsp_hold = 0;
				hold_active = 1'b1;
				irq_rsp.ready <= 1'b0;
				repeat (off_len) @(posedge clk);
				hold_active = 1'b0;
			end
			on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			irq_rsp.ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			off_len = pick_gap();
			if (off_len > 0) begin
				irq_rsp.ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && irq_rsp.valid && irq_rsp.ready) begin
			seen.status  = status_t'(irq_rsp.status);
			seen.line    = irq_rsp.line_out;
			seen.drained = irq_rsp.drained_count;
			seen.last    = irq_rsp.last_result;
			seen.fires   = irq_rsp.fire_count_out;
			seen.queued  = irq_rsp.queued_total_out;
			seen.dropped = irq_rsp.dropped_total_out;
			if (irq_results_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result: %s", fmt_result(seen));
			end else begin
				want = irq_results_q.pop_front();
				if (seen.status !== want.status || seen.line !== want.line ||
					seen.drained !== want.drained || seen.last !== want.last ||
					seen.fires !== want.fires || seen.queued !== want.queued ||
					seen.dropped !== want.dropped) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected %s", fmt_result(want));
						$display("  actual   %s", fmt_result(seen));
					end
				end
			end
		end
	end

	// Fires at both line extremes, stats at the top line, an empty drain, an unused operation
	task automatic test_immediate_basics();
		send_request(OP_FIRE, '0);
		send_request(OP_FIRE, '1);
		send_request(OP_STATS, '1);
		send_request(OP_DRAIN, '0);
		send_request(OP_UNUSED, 5'd9);
		settle_block();
	endtask

	// Lines masked by their mask bit, then everything masked by the global enable
	task automatic test_masking();
		write_reg(CFG_LINE_MASK, 32'h7FFF_FFFE);
		send_request(OP_FIRE, '0);
		send_request(OP_FIRE, '1);
		send_request(OP_FIRE, 5'd1);
		settle_block();
		write_reg(CFG_GLOBAL_ENABLE, 32'd0);
		send_request(OP_FIRE, 5'd1);
		settle_block();
		write_reg(CFG_GLOBAL_ENABLE, 32'd1);
		write_reg(CFG_LINE_MASK, '1);
	endtask

	// Fill the queue, drop one, switch mode without flushing, drain in immediate mode
	task automatic test_queue_overflow();
		write_reg(CFG_DEFERRED, 32'd1);
		for (int i = 0; i <= DEF_QUEUE_DEPTH; i++)
			send_request(OP_FIRE, LINE_W'(i * 7));
		settle_block();
		write_reg(CFG_DEFERRED, 32'd0);
		send_request(OP_FIRE, 5'd3);
		send_request(OP_DRAIN, '0);
		settle_block();
	endtask

	task automatic test_random_immediate();
		for (int i = 0; i < 40; i++)
			send_request(pick_op(5), pick_line());
		settle_block();
	endtask

	// Bursts of fires closed by a drain; some sequences start with a bare drain
	task automatic test_deferred_bursts();
		int sent;
		int burst;
		sent = 0;
		write_reg(CFG_LINE_MASK, $urandom);
		write_reg(CFG_DEFERRED, 32'd1);
		while (sent < 60) begin
			if ($urandom_range(0, 7) == 0) begin
				send_request(OP_DRAIN, pick_line());
				sent++;
			end
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst; i++)
				send_request(($urandom_range(0, 9) == 0) ? OP_STATS : OP_FIRE, pick_line());
			send_request(OP_DRAIN, pick_line());
			if ($urandom_range(0, 3) == 0)
				send_request(OP_DRAIN, pick_line());
			sent += burst + 1;
		end
		settle_block();
	endtask

	// Hold the receiver off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		write_reg(CFG_LINE_MASK, '1);
		write_reg(CFG_DEFERRED, 32'd0);
		rsp_hold = 300;
		while (!hold_active) @(posedge clk);
		no_gaps = 1'b1;
		for (int i = 0; i < 40; i++)
			send_request(pick_op(5), pick_line());
		no_gaps = 1'b0;
		settle_block();
	endtask

	task automatic test_disabled();
		write_reg(CFG_GLOBAL_ENABLE, 32'd0);
		write_reg(CFG_LINE_MASK, '0);
		write_reg(CFG_DEFERRED, 32'd1);
		for (int i = 0; i < 15; i++)
			send_request(pick_op(15), pick_line());
		settle_block();
		write_reg(CFG_GLOBAL_ENABLE, 32'd1);
	endtask

	// Several mask and mode settings, one of them without any idling
	task automatic test_random_mixed();
		logic [CFG_DAT_W-1:0] mask;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: mask = '1;
				1: mask = $urandom;
				2: mask = $urandom | $urandom;
				default: mask = $urandom & $urandom;
			endcase
			write_reg(CFG_LINE_MASK, mask);
			write_reg(CFG_DEFERRED, k % 2);
			no_gaps = (k == 2);
			for (int i = 0; i < 18; i++)
				send_request(pick_op((k % 2) ? 12 : 5), pick_line());
			no_gaps = 1'b0;
			settle_block();
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		irq_req.valid     <= 1'b0;
		irq_req.operation <= OP_FIRE;
		irq_req.irq_line  <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.index     <= CFG_GLOBAL_ENABLE;
		cfg_bus.data      <= '0;
		glb_en      = 1'b1;
		line_mask   = '1;
		defer_mode  = 1'b0;
		ring_head   = 0;
		ring_tail   = 0;
		ring_fill   = 0;
		queued_tot  = '0;
		dropped_tot = '0;
		for (int i = 0; i < DEF_NUM_LINES; i++)
			fire_cnt[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_immediate_basics();
		test_masking();
		test_queue_overflow();
		test_random_immediate();
		test_deferred_bursts();
		test_backpressure();
		test_disabled();
		test_random_mixed();

		if (fail_count == 0 && irq_results_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
